// ===== design/asbk_pkg.sv =====
// ----------------------------------------------------------------------------
// asbk_pkg
// Shared constants, codes and the bank entry layout for the aerodynamic
// sample bank with kernel-weighted estimation.
// ----------------------------------------------------------------------------
package asbk_pkg;

    localparam int BANK_DEPTH_DEFAULT = 64;

    // Request codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [2:0] STAT_STORED = 3'd0;
    localparam logic [2:0] STAT_REJECT = 3'd1;
    localparam logic [2:0] STAT_FULL   = 3'd2;
    localparam logic [2:0] STAT_HIT    = 3'd3;
    localparam logic [2:0] STAT_MISS   = 3'd4;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // ceil(2^23 / 10) and ceil(2^31 / 100), exact over the ranges used.
    localparam logic [19:0] RECIP10  = 20'd838861;
    localparam logic [24:0] RECIP100 = 25'd21474837;

    // One bank entry. The pressure is kept as its Q16 base-2 logarithm.
    typedef struct packed {
        logic [20:0] logq;
        logic [23:0] mach;
        logic [24:0] attack;
        logic [24:0] slip;
        logic [31:0] drag;
        logic [31:0] lift;
        logic [31:0] side;
        logic [2:0]  frame;
        logic [15:0] obs;
        logic [16:0] trust;
    } entry_t;

endpackage

// ===== design/aero_sample_bank_kernel_estimate.sv =====
// ----------------------------------------------------------------------------
// aero_sample_bank_kernel_estimate
// Bank of aerodynamic samples with a kernel-weighted acceleration estimate.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  request   in_valid / in_ready   opcode, dyn_pressure ... observation_count
//  result    out_valid / out_ready status, accel_*, estimate_confidence
//
//  One request is worked on at a time; a new one is taken as soon as the
//  previous result sits in the output register.
//  Insert: log2 through the 5-step normalise and 16-step squaring, then a write.
//  Query: log2, then per stored sample a read and the distance checks; a sample
//  whose frame bits or ranges fail, or that lies outside the radius, is skipped,
//  else it is weighted after a bit-serial square root; then the shared bit-serial
//  divider gives seven 32-bit quotients.
//  Reset empties the bank at once; the entries themselves are not cleared.
//  A stalled result holds the block in its final state until taken.
// ----------------------------------------------------------------------------
module aero_sample_bank_kernel_estimate #(
    parameter int BANK_DEPTH = asbk_pkg::BANK_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [31:0]        dyn_pressure,
    input  logic [23:0]        mach_number,
    input  logic signed [24:0] attack_angle,
    input  logic signed [24:0] slip_angle,
    input  logic [31:0]        vehicle_mass,
    input  logic signed [31:0] drag_per_q,
    input  logic signed [31:0] lift_per_q,
    input  logic signed [31:0] side_per_q,
    input  logic [2:0]         airframe_bits,
    input  logic [15:0]        sample_trust,
    input  logic [15:0]        observation_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] accel_drag,
    output logic signed [31:0] accel_lift,
    output logic signed [31:0] accel_side,
    output logic [16:0]        estimate_confidence
);

    localparam int CNT_W  = $clog2(BANK_DEPTH + 1);
    localparam int ADDR_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int ACC_W  = 64 + CNT_W;
    localparam int WS_W   = 32 + CNT_W;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_LOG_NORM = 5'd1;
    localparam logic [4:0] ST_LOG_SQ   = 5'd2;
    localparam logic [4:0] ST_INS_WR   = 5'd3;
    localparam logic [4:0] ST_W_ISSUE  = 5'd4;
    localparam logic [4:0] ST_W_D0     = 5'd5;
    localparam logic [4:0] ST_W_D1     = 5'd6;
    localparam logic [4:0] ST_W_D2     = 5'd7;
    localparam logic [4:0] ST_W_D3     = 5'd8;
    localparam logic [4:0] ST_W_D4     = 5'd9;
    localparam logic [4:0] ST_W_D5     = 5'd10;
    localparam logic [4:0] ST_SQRT     = 5'd11;
    localparam logic [4:0] ST_K0       = 5'd12;
    localparam logic [4:0] ST_K1       = 5'd13;
    localparam logic [4:0] ST_K2       = 5'd14;
    localparam logic [4:0] ST_K3       = 5'd15;
    localparam logic [4:0] ST_K4       = 5'd16;
    localparam logic [4:0] ST_F_CHECK  = 5'd17;
    localparam logic [4:0] ST_F_LOAD   = 5'd18;
    localparam logic [4:0] ST_F_MUL    = 5'd19;
    localparam logic [4:0] ST_F_DIV    = 5'd20;
    localparam logic [4:0] ST_F_POST   = 5'd21;
    localparam logic [4:0] ST_DONE     = 5'd22;

    // Finishing sequence: three means, confidence, three scalings.
    localparam logic [2:0] SEL_CONF   = 3'd3;
    localparam logic [2:0] SEL_SCALE0 = 3'd4;
    localparam logic [2:0] SEL_LAST   = 3'd6;

    localparam logic [4:0] NORM_LAST = 5'd4;
    localparam logic [4:0] SQ_LAST   = 5'd15;
    localparam logic [4:0] DIV_LAST  = 5'd31;

    // Control state
    logic [4:0]       state_reg, state_next;
    logic [4:0]       step_cnt_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [2:0]       fin_sel_reg;
    logic             out_valid_reg;

    // Captured request
    logic        op_reg;
    logic [31:0] q_reg, mass_reg;
    logic [23:0] mach_reg;
    logic [24:0] attack_reg, slip_reg;
    logic [31:0] drag_reg, lift_reg, side_reg;
    logic [2:0]  bits_reg;
    logic [15:0] trust_reg, obs_reg;

    // Memory
    asbk_pkg::entry_t bank_mem [BANK_DEPTH];
    asbk_pkg::entry_t rd_entry_reg;
    asbk_pkg::entry_t wr_entry;

    // log2 unit
    logic [31:0] log_y_reg;
    logic [4:0]  log_p_reg;
    logic [15:0] log_frac_reg;
    logic [20:0] lq_reg;

    // Distance pipeline
    logic [15:0] adq_reg, adm_reg;
    logic [19:0] ma_reg, mb_reg;
    logic [31:0] sqq_reg, sqm_reg;
    logic [15:0] qa_reg, qb_reg;
    logic [3:0]  ra_reg, rb_reg;
    logic [31:0] qa2_reg, qb2_reg;
    logic [23:0] ta_reg, tb_reg;
    logic [32:0] sa_reg, sb_reg;

    // Square root
    logic [31:0] sq_rem_reg, sq_res_reg, sq_bit_reg;

    // Weights and sums
    logic [16:0]      compact_reg, kernel_reg;
    logic [31:0]      base_reg, w_reg, cw_reg;
    logic [63:0]      pd_reg [3];
    logic [ACC_W-1:0] acc_reg [3];
    logic [WS_W-1:0]  wsum_reg, lsum_reg, csum_reg;

    // Divider and finishing
    logic [ACC_W-1:0] div_rem_reg, div_den_reg;
    logic [31:0]      div_quo_reg;
    logic [63:0]      prod_reg;
    logic             sat_reg;
    logic             neg_reg [3];
    logic [31:0]      mag_reg [3];

    // Result and output registers
    logic [2:0]  res_status_reg;
    logic [31:0] res_force_reg [3];
    logic [16:0] res_conf_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_force_reg [3];
    logic [16:0] out_conf_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic in_fire, out_free;
    logic ins_reject, qry_reject, bank_full;
    logic last_sample, advance;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign ins_reject = (dyn_pressure == 32'd0) || (vehicle_mass == 32'd0)
                        || (sample_trust == 16'd0);
    assign qry_reject = (dyn_pressure == 32'd0) || (vehicle_mass == 32'd0);
    assign bank_full  = (count_reg >= CNT_W'(BANK_DEPTH));
    assign last_sample = (CNT_W'(idx_reg + 1'b1) == count_reg);

    // Normalising shift of the log2 unit, largest step first.
    logic [4:0]  norm_amt;
    logic        norm_zero;
    logic [31:0] norm_y;

    always_comb
    begin
        norm_amt  = 5'd0;
        norm_zero = 1'b0;
        norm_y    = log_y_reg;
        unique case (step_cnt_reg)
            5'd0:
            begin
                norm_amt  = 5'd16;
                norm_zero = (log_y_reg[31:16] == 16'd0);
                norm_y    = {log_y_reg[15:0], 16'd0};
            end
            5'd1:
            begin
                norm_amt  = 5'd8;
                norm_zero = (log_y_reg[31:24] == 8'd0);
                norm_y    = {log_y_reg[23:0], 8'd0};
            end
            5'd2:
            begin
                norm_amt  = 5'd4;
                norm_zero = (log_y_reg[31:28] == 4'd0);
                norm_y    = {log_y_reg[27:0], 4'd0};
            end
            5'd3:
            begin
                norm_amt  = 5'd2;
                norm_zero = (log_y_reg[31:30] == 2'd0);
                norm_y    = {log_y_reg[29:0], 2'd0};
            end
            5'd4:
            begin
                norm_amt  = 5'd1;
                norm_zero = !log_y_reg[31];
                norm_y    = {log_y_reg[30:0], 1'b0};
            end
            default:
            begin
                norm_amt  = 5'd0;
                norm_zero = 1'b0;
                norm_y    = log_y_reg;
            end
        endcase
    end

    // Squaring step: the mantissa stays in [2^31, 2^32).
    logic [63:0] log_sq;
    logic [32:0] log_y2;
    assign log_sq = 64'(log_y_reg) * 64'(log_y_reg);
    assign log_y2 = log_sq[63:31];

    // Distance terms against the entry read last cycle.
    logic [21:0] dq_c, adq_c;
    logic [24:0] dmach_c;
    logic [25:0] dm_c, adm_c, da_c, ma_c, db_c, mb_c;
    logic        skip_d0;

    assign dq_c    = {1'b0, lq_reg} - {1'b0, rd_entry_reg.logq};
    assign adq_c   = dq_c[21] ? (22'd0 - dq_c) : dq_c;
    assign dmach_c = {1'b0, mach_reg} - {1'b0, rd_entry_reg.mach};
    assign dm_c    = {dmach_c, 1'b0};
    assign adm_c   = dm_c[25] ? (26'd0 - dm_c) : dm_c;
    assign da_c    = {attack_reg[24], attack_reg}
                     - {rd_entry_reg.attack[24], rd_entry_reg.attack};
    assign ma_c    = da_c[25] ? (26'd0 - da_c) : da_c;
    assign db_c    = {slip_reg[24], slip_reg}
                     - {rd_entry_reg.slip[24], rd_entry_reg.slip};
    assign mb_c    = db_c[25] ? (26'd0 - db_c) : db_c;
    assign skip_d0 = (rd_entry_reg.frame != bits_reg) || (adq_c >= 22'd65536)
                     || (adm_c >= 26'd65536) || (ma_c >= 26'd655360)
                     || (mb_c >= 26'd655360);

    // Angle terms: m = 10a + b, so m^2/100 = a^2 + (20ab + b^2)/100.
    logic [39:0] qa_prod, qb_prod;
    logic [19:0] ra_c, rb_c;
    logic [23:0] ta_c, tb_c;
    logic [48:0] tap, tbp;

    assign qa_prod = 40'(ma_reg) * 40'(asbk_pkg::RECIP10);
    assign qb_prod = 40'(mb_reg) * 40'(asbk_pkg::RECIP10);
    assign ra_c    = ma_reg - 20'(qa_reg) * 20'd10;
    assign rb_c    = mb_reg - 20'(qb_reg) * 20'd10;
    assign ta_c    = 24'd20 * (24'(qa_reg) * 24'(ra_reg)) + 24'(ra_reg) * 24'(ra_reg);
    assign tb_c    = 24'd20 * (24'(qb_reg) * 24'(rb_reg)) + 24'(rb_reg) * 24'(rb_reg);
    assign tap     = 49'(ta_reg) * 49'(asbk_pkg::RECIP100);
    assign tbp     = 49'(tb_reg) * 49'(asbk_pkg::RECIP100);

    logic [34:0] r2_c;
    logic        skip_d5;
    assign r2_c    = 35'(sqq_reg) + 35'(sqm_reg) + 35'(sa_reg) + 35'(sb_reg);
    assign skip_d5 = (r2_c[34:32] != 3'd0);

    logic [32:0] sq_trial;
    logic        sq_take;
    assign sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_take  = ({1'b0, sq_rem_reg} >= sq_trial);

    logic [16:0] compact_c;
    logic [33:0] kp;
    logic [32:0] bp;
    logic [48:0] wp, cwp;
    assign compact_c = asbk_pkg::ONE_Q16 - 17'(sq_res_reg[15:0]);
    assign kp  = 34'(compact_c) * 34'(compact_c);
    assign bp  = 33'(kernel_reg) * 33'(rd_entry_reg.obs);
    assign wp  = 49'(base_reg) * 49'(rd_entry_reg.trust);
    assign cwp = 49'(w_reg) * 49'(compact_reg);

    assign advance = ((state_reg == ST_W_D0) && skip_d0)
                     || ((state_reg == ST_W_D5) && skip_d5)
                     || (state_reg == ST_K4);

    logic div_take;
    logic prod_sat;
    assign div_take = (div_rem_reg >= div_den_reg);
    assign prod_sat = (prod_reg[63:32] >= mass_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == asbk_pkg::OP_INSERT)
                        state_next = (ins_reject || bank_full) ? ST_DONE : ST_LOG_NORM;
                    else
                        state_next = qry_reject ? ST_DONE : ST_LOG_NORM;
                end
            end
            ST_LOG_NORM:
                if (step_cnt_reg == NORM_LAST)
                    state_next = ST_LOG_SQ;
            ST_LOG_SQ:
            begin
                if (step_cnt_reg == SQ_LAST)
                begin
                    if (op_reg == asbk_pkg::OP_INSERT)
                        state_next = ST_INS_WR;
                    else
                        state_next = (count_reg == '0) ? ST_DONE : ST_W_ISSUE;
                end
            end
            ST_INS_WR:  state_next = ST_DONE;
            ST_W_ISSUE: state_next = ST_W_D0;
            ST_W_D0:    state_next = skip_d0 ? (last_sample ? ST_F_CHECK : ST_W_ISSUE)
                                             : ST_W_D1;
            ST_W_D1:    state_next = ST_W_D2;
            ST_W_D2:    state_next = ST_W_D3;
            ST_W_D3:    state_next = ST_W_D4;
            ST_W_D4:    state_next = ST_W_D5;
            ST_W_D5:    state_next = skip_d5 ? (last_sample ? ST_F_CHECK : ST_W_ISSUE)
                                             : ST_SQRT;
            ST_SQRT:
                if (step_cnt_reg == SQ_LAST)
                    state_next = ST_K0;
            ST_K0:      state_next = ST_K1;
            ST_K1:      state_next = ST_K2;
            ST_K2:      state_next = ST_K3;
            ST_K3:      state_next = ST_K4;
            ST_K4:      state_next = last_sample ? ST_F_CHECK : ST_W_ISSUE;
            ST_F_CHECK:
                state_next = ((wsum_reg == '0) || (lsum_reg == '0)) ? ST_DONE : ST_F_LOAD;
            ST_F_LOAD:
                state_next = (fin_sel_reg >= SEL_SCALE0) ? ST_F_MUL : ST_F_DIV;
            ST_F_MUL:   state_next = prod_sat ? ST_F_POST : ST_F_DIV;
            ST_F_DIV:
                if (step_cnt_reg == DIV_LAST)
                    state_next = ST_F_POST;
            ST_F_POST:  state_next = (fin_sel_reg == SEL_LAST) ? ST_DONE : ST_F_LOAD;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= 5'd0;
            count_reg     <= '0;
            idx_reg       <= '0;
            fin_sel_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= (state_next != state_reg) ? 5'd0 : 5'(step_cnt_reg + 1'b1);
            if (state_reg == ST_INS_WR)
                count_reg <= CNT_W'(count_reg + 1'b1);
            if (state_reg == ST_LOG_SQ)
                idx_reg <= '0;
            else if (advance && !last_sample)
                idx_reg <= CNT_W'(idx_reg + 1'b1);
            if (state_reg == ST_F_CHECK)
                fin_sel_reg <= 3'd0;
            else if (state_reg == ST_F_POST)
                fin_sel_reg <= 3'(fin_sel_reg + 1'b1);
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sample memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_entry.logq   = lq_reg;
        wr_entry.mach   = mach_reg;
        wr_entry.attack = attack_reg;
        wr_entry.slip   = slip_reg;
        wr_entry.drag   = drag_reg;
        wr_entry.lift   = lift_reg;
        wr_entry.side   = side_reg;
        wr_entry.frame  = bits_reg;
        wr_entry.obs    = (obs_reg == 16'd0) ? 16'd1 : obs_reg;
        wr_entry.trust  = {1'b0, trust_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INS_WR)
            bank_mem[count_reg[ADDR_W-1:0]] <= wr_entry;
        rd_entry_reg <= bank_mem[idx_reg[ADDR_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg       <= opcode;
                    q_reg        <= dyn_pressure;
                    mass_reg     <= vehicle_mass;
                    mach_reg     <= mach_number;
                    attack_reg   <= attack_angle;
                    slip_reg     <= slip_angle;
                    drag_reg     <= drag_per_q;
                    lift_reg     <= lift_per_q;
                    side_reg     <= side_per_q;
                    bits_reg     <= airframe_bits;
                    trust_reg    <= sample_trust;
                    obs_reg      <= observation_count;
                    log_y_reg    <= dyn_pressure;
                    log_p_reg    <= 5'd31;
                    log_frac_reg <= 16'd0;
                    for (int k = 0; k < 3; k++)
                    begin
                        res_force_reg[k] <= 32'd0;
                        acc_reg[k]       <= '0;
                    end
                    res_conf_reg <= 17'd0;
                    wsum_reg     <= '0;
                    lsum_reg     <= '0;
                    csum_reg     <= '0;
                    if (opcode == asbk_pkg::OP_INSERT)
                    begin
                        if (ins_reject)
                            res_status_reg <= asbk_pkg::STAT_REJECT;
                        else if (bank_full)
                            res_status_reg <= asbk_pkg::STAT_FULL;
                        else
                            res_status_reg <= asbk_pkg::STAT_STORED;
                    end
                    else
                        res_status_reg <= asbk_pkg::STAT_MISS;
                end
            end
            ST_LOG_NORM:
            begin
                if (norm_zero)
                begin
                    log_y_reg <= norm_y;
                    log_p_reg <= log_p_reg - norm_amt;
                end
            end
            ST_LOG_SQ:
            begin
                log_y_reg    <= log_y2[32] ? log_y2[32:1] : log_y2[31:0];
                log_frac_reg <= {log_frac_reg[14:0], log_y2[32]};
                if (step_cnt_reg == SQ_LAST)
                    lq_reg <= {log_p_reg, log_frac_reg[14:0], log_y2[32]};
            end
            ST_W_D0:
            begin
                adq_reg <= adq_c[15:0];
                adm_reg <= adm_c[15:0];
                ma_reg  <= ma_c[19:0];
                mb_reg  <= mb_c[19:0];
            end
            ST_W_D1:
            begin
                sqq_reg <= 32'(adq_reg) * 32'(adq_reg);
                sqm_reg <= 32'(adm_reg) * 32'(adm_reg);
                qa_reg  <= qa_prod[38:23];
                qb_reg  <= qb_prod[38:23];
            end
            ST_W_D2:
            begin
                ra_reg  <= ra_c[3:0];
                rb_reg  <= rb_c[3:0];
                qa2_reg <= 32'(qa_reg) * 32'(qa_reg);
                qb2_reg <= 32'(qb_reg) * 32'(qb_reg);
            end
            ST_W_D3:
            begin
                ta_reg <= ta_c;
                tb_reg <= tb_c;
            end
            ST_W_D4:
            begin
                sa_reg <= 33'(qa2_reg) + 33'(tap[47:31]);
                sb_reg <= 33'(qb2_reg) + 33'(tbp[47:31]);
            end
            ST_W_D5:
            begin
                sq_rem_reg <= r2_c[31:0];
                sq_res_reg <= 32'd0;
                sq_bit_reg <= 32'h4000_0000;
            end
            ST_SQRT:
            begin
                if (sq_take)
                begin
                    sq_rem_reg <= sq_rem_reg - sq_trial[31:0];
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_K0:
            begin
                compact_reg <= compact_c;
                kernel_reg  <= kp[32:16];
            end
            ST_K1:
                base_reg <= bp[31:0];
            ST_K2:
                w_reg <= wp[47:16];
            ST_K3:
            begin
                // Forces are biased by half range so the sums stay unsigned.
                cw_reg    <= cwp[47:16];
                pd_reg[0] <= 64'({~rd_entry_reg.drag[31], rd_entry_reg.drag[30:0]})
                             * 64'(w_reg);
                pd_reg[1] <= 64'({~rd_entry_reg.lift[31], rd_entry_reg.lift[30:0]})
                             * 64'(w_reg);
                pd_reg[2] <= 64'({~rd_entry_reg.side[31], rd_entry_reg.side[30:0]})
                             * 64'(w_reg);
            end
            ST_K4:
            begin
                for (int k = 0; k < 3; k++)
                    acc_reg[k] <= acc_reg[k] + ACC_W'(pd_reg[k]);
                wsum_reg <= wsum_reg + WS_W'(w_reg);
                lsum_reg <= lsum_reg + WS_W'(base_reg);
                csum_reg <= csum_reg + WS_W'(cw_reg);
            end
            ST_F_LOAD:
            begin
                div_quo_reg <= 32'd0;
                if (fin_sel_reg == SEL_CONF)
                begin
                    div_rem_reg <= ACC_W'(csum_reg) << 16;
                    div_den_reg <= ACC_W'(lsum_reg) << 31;
                end
                else if (fin_sel_reg < SEL_CONF)
                begin
                    div_rem_reg <= acc_reg[fin_sel_reg[1:0]];
                    div_den_reg <= ACC_W'(wsum_reg) << 31;
                end
                else
                    prod_reg <= 64'(mag_reg[fin_sel_reg[1:0]]) * 64'(q_reg);
            end
            ST_F_MUL:
            begin
                // A quotient of 2^32 or more saturates whatever its low bits.
                sat_reg     <= prod_sat;
                div_quo_reg <= 32'd0;
                div_rem_reg <= ACC_W'(prod_reg);
                div_den_reg <= ACC_W'(mass_reg) << 31;
            end
            ST_F_DIV:
            begin
                if (div_take)
                    div_rem_reg <= div_rem_reg - div_den_reg;
                div_quo_reg <= {div_quo_reg[30:0], div_take};
                div_den_reg <= div_den_reg >> 1;
            end
            ST_F_POST:
            begin
                if (fin_sel_reg == SEL_CONF)
                    res_conf_reg <= (div_quo_reg > 32'(asbk_pkg::ONE_Q16))
                                    ? asbk_pkg::ONE_Q16 : div_quo_reg[16:0];
                else if (fin_sel_reg < SEL_CONF)
                begin
                    neg_reg[fin_sel_reg[1:0]] <= !div_quo_reg[31];
                    mag_reg[fin_sel_reg[1:0]] <= div_quo_reg[31]
                        ? {1'b0, div_quo_reg[30:0]}
                        : (32'h8000_0000 - div_quo_reg);
                end
                else
                begin
                    if (neg_reg[fin_sel_reg[1:0]])
                        res_force_reg[fin_sel_reg[1:0]] <=
                            (sat_reg || (div_quo_reg > 32'h8000_0000))
                            ? 32'h8000_0000 : (32'd0 - div_quo_reg);
                    else
                        res_force_reg[fin_sel_reg[1:0]] <=
                            (sat_reg || div_quo_reg[31]) ? 32'h7FFF_FFFF : div_quo_reg;
                    if (fin_sel_reg == SEL_LAST)
                        res_status_reg <= asbk_pkg::STAT_HIT;
                end
            end
            default:
            begin
            end
        endcase

        if ((state_reg == ST_DONE) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_force_reg  <= res_force_reg;
            out_conf_reg   <= res_conf_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = out_status_reg;
    assign accel_drag          = out_force_reg[0];
    assign accel_lift          = out_force_reg[1];
    assign accel_side          = out_force_reg[2];
    assign estimate_confidence = out_conf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BANK_DEPTH))
        else $error("stored count beyond bank depth");

    count_moves_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_INS_WR) |=> $stable(count_reg))
        else $error("stored count changed outside an insert write");

    walk_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W_D0) |-> (idx_reg < count_reg))
        else $error("query visited an entry that was never stored");

    sqrt_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K0) |-> (sq_res_reg[31:16] == 16'd0))
        else $error("square root exceeds unit radius");

    conf_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_F_POST) && (fin_sel_reg == SEL_CONF))
        |-> (div_quo_reg <= 32'(asbk_pkg::ONE_Q16)))
        else $error("confidence sum exceeded observation sum");

endmodule

// ===== bench/aero_sample_bank_kernel_estimate_test.sv =====
// ----------------------------------------------------------------------------
// Aerodynamic sample bank testbench
// Drives insert and query requests with random gaps on both channels.
// A scoreboard class keeps its own copy of the bank, predicts the status,
// accelerations and confidence of every accepted request, and checks each
// result field by field in order.
// ----------------------------------------------------------------------------
module aero_sample_bank_kernel_estimate_test;
    timeunit 1ns;
    timeprecision 1ps;

    import asbk_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_REQUESTS = 1300;

    typedef struct {
        logic               op;
        logic [31:0]        q;
        logic [23:0]        mach;
        logic signed [24:0] aoa;
        logic signed [24:0] beta;
        logic [31:0]        mass;
        logic signed [31:0] drag;
        logic signed [31:0] lift;
        logic signed [31:0] side;
        logic [2:0]         frame;
        logic [15:0]        trust;
        logic [15:0]        obs;
    } request_t;

    typedef struct {
        logic [2:0]  st;
        logic [31:0] ad;
        logic [31:0] al;
        logic [31:0] aside;
        logic [16:0] conf;
    } estimate_t;

    class kernel_scoreboard;
        int          errors;
        int          count;
        int unsigned b_pres[DEPTH];
        int unsigned b_mach[DEPTH];
        int          b_att[DEPTH];
        int          b_slp[DEPTH];
        int          b_force[DEPTH][3];
        int unsigned b_frame[DEPTH];
        int unsigned b_obs[DEPTH];
        int unsigned b_trust[DEPTH];
        estimate_t   expected_q[$];

        function new();
            errors = 0;
            count  = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function int unsigned log2_q16(logic [31:0] x);
            int                p;
            longint unsigned   y;
            int unsigned       frac;
            p    = 31;
            frac = 0;
            while (p > 0 && x[p] == 1'b0)
                p--;
            y = {32'b0, x} << (31 - p);
            for (int i = 0; i < 16; i++)
            begin
                y = (y * y) >> 31;
                if (y >= 64'h1_0000_0000)
                begin
                    y = y >> 1;
                    frac = frac | (32'd1 << (15 - i));
                end
            end
            return (p << 16) | frac;
        endfunction

        function longint unsigned root64(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Weighted mean with the offset removed, scaled by q/mass, saturated.
        function logic [31:0] scale_accel(logic [127:0] fsum, longint unsigned wsum,
                                          logic [31:0] q, logic [31:0] mass);
            logic [127:0]    quo;
            longint          mean;
            longint unsigned mag;
            longint unsigned a;
            quo  = fsum / {64'b0, wsum};
            mean = longint'(quo[63:0]) - 64'sd2147483648;
            mag  = (mean < 0) ? longint'(-mean) : longint'(mean);
            a    = (mag * {32'b0, q}) / {32'b0, mass};
            if (mean < 0)
            begin
                if (a > 64'd2147483648)
                    a = 64'd2147483648;
                return 32'd0 - a[31:0];
            end
            if (a > 64'd2147483647)
                a = 64'd2147483647;
            return a[31:0];
        endfunction

        function estimate_t predict(request_t r);
            estimate_t       e;
            longint          lq, dq, dm, da, db;
            longint unsigned sa, sb, r2, rt, compact, kernel, base, w, cw, p;
            longint unsigned wsum, lsum, csum, c;
            logic [127:0]    fsum[3];
            e = '{STAT_MISS, 32'd0, 32'd0, 32'd0, 17'd0};
            if (r.op == OP_INSERT)
            begin
                if (r.q == 0 || r.mass == 0 || r.trust == 0)
                    e.st = STAT_REJECT;
                else if (count >= DEPTH)
                    e.st = STAT_FULL;
                else
                begin
                    b_pres[count]     = r.q;
                    b_mach[count]     = r.mach;
                    b_att[count]      = r.aoa;
                    b_slp[count]      = r.beta;
                    b_force[count][0] = r.drag;
                    b_force[count][1] = r.lift;
                    b_force[count][2] = r.side;
                    b_frame[count]    = r.frame;
                    b_obs[count]      = (r.obs == 0) ? 1 : r.obs;
                    b_trust[count]    = r.trust;
                    count++;
                    e.st = STAT_STORED;
                end
                return e;
            end
            if (r.q == 0 || r.mass == 0)
                return e;
            wsum = 0;
            lsum = 0;
            csum = 0;
            for (int k = 0; k < 3; k++)
                fsum[k] = '0;
            lq = log2_q16(r.q);
            for (int i = 0; i < count; i++)
            begin
                if (b_frame[i] != r.frame || b_pres[i] == 0 || b_trust[i] == 0)
                    continue;
                dq = lq - longint'(log2_q16(b_pres[i]));
                if (dq <= -65536 || dq >= 65536)
                    continue;
                dm = 2 * (longint'(r.mach) - longint'(b_mach[i]));
                if (dm <= -65536 || dm >= 65536)
                    continue;
                da = longint'(r.aoa) - longint'(b_att[i]);
                db = longint'(r.beta) - longint'(b_slp[i]);
                if (da < 0)
                    da = -da;
                if (db < 0)
                    db = -db;
                if (da >= 655360 || db >= 655360)
                    continue;
                sa = (da * da) / 100;
                sb = (db * db) / 100;
                r2 = dq * dq + dm * dm + sa + sb;
                if (r2 >= 64'h1_0000_0000)
                    continue;
                rt      = root64(r2);
                compact = 65536 - rt;
                kernel  = (compact * compact) >> 16;
                base    = kernel * b_obs[i];
                w       = (base * b_trust[i]) >> 16;
                cw      = (w * compact) >> 16;
                for (int k = 0; k < 3; k++)
                begin
                    p = longint'(b_force[i][k]) + 64'sd2147483648;
                    p = p * w;
                    fsum[k] = fsum[k] + {64'b0, p};
                end
                wsum += w;
                lsum += base;
                csum += cw;
            end
            if (wsum == 0 || lsum == 0)
                return e;
            e.st    = STAT_HIT;
            e.ad    = scale_accel(fsum[0], wsum, r.q, r.mass);
            e.al    = scale_accel(fsum[1], wsum, r.q, r.mass);
            e.aside = scale_accel(fsum[2], wsum, r.q, r.mass);
            c = (csum << 16) / lsum;
            if (c > 65536)
                c = 65536;
            e.conf = c[16:0];
            return e;
        endfunction

        function void note_request(request_t r);
            expected_q.push_back(predict(r));
        endfunction

        function void check_result(estimate_t act);
            estimate_t exp_e;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding, status %0d", act.st);
                errors++;
                return;
            end
            exp_e = expected_q.pop_front();
            if (act.st !== exp_e.st)
            begin
                $error("status: expected %0d, got %0d", exp_e.st, act.st);
                errors++;
            end
            if (act.ad !== exp_e.ad)
            begin
                $error("accel_drag: expected %h, got %h", exp_e.ad, act.ad);
                errors++;
            end
            if (act.al !== exp_e.al)
            begin
                $error("accel_lift: expected %h, got %h", exp_e.al, act.al);
                errors++;
            end
            if (act.aside !== exp_e.aside)
            begin
                $error("accel_side: expected %h, got %h", exp_e.aside, act.aside);
                errors++;
            end
            if (act.conf !== exp_e.conf)
            begin
                $error("estimate_confidence: expected %h, got %h", exp_e.conf, act.conf);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic [31:0]        dyn_pressure;
    logic [23:0]        mach_number;
    logic signed [24:0] attack_angle;
    logic signed [24:0] slip_angle;
    logic [31:0]        vehicle_mass;
    logic signed [31:0] drag_per_q;
    logic signed [31:0] lift_per_q;
    logic signed [31:0] side_per_q;
    logic [2:0]         airframe_bits;
    logic [15:0]        sample_trust;
    logic [15:0]        observation_count;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic signed [31:0] accel_drag;
    logic signed [31:0] accel_lift;
    logic signed [31:0] accel_side;
    logic [16:0]        estimate_confidence;

    kernel_scoreboard sb;
    int               sent;

    aero_sample_bank_kernel_estimate u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (opcode),
        .dyn_pressure        (dyn_pressure),
        .mach_number         (mach_number),
        .attack_angle        (attack_angle),
        .slip_angle          (slip_angle),
        .vehicle_mass        (vehicle_mass),
        .drag_per_q          (drag_per_q),
        .lift_per_q          (lift_per_q),
        .side_per_q          (side_per_q),
        .airframe_bits       (airframe_bits),
        .sample_trust        (sample_trust),
        .observation_count   (observation_count),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .status              (status),
        .accel_drag          (accel_drag),
        .accel_lift          (accel_lift),
        .accel_side          (accel_side),
        .estimate_confidence (estimate_confidence)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Roughly one run in eight offers back-to-back with no idling at all.
    function automatic int draw_gap(int n);
        if ((n / 40) % 8 == 3)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    task automatic send_request(request_t r);
        int gap;
        gap = draw_gap(sent);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode            <= r.op;
        dyn_pressure      <= r.q;
        mach_number       <= r.mach;
        attack_angle      <= r.aoa;
        slip_angle        <= r.beta;
        vehicle_mass      <= r.mass;
        drag_per_q        <= r.drag;
        lift_per_q        <= r.lift;
        side_per_q        <= r.side;
        airframe_bits     <= r.frame;
        sample_trust      <= r.trust;
        observation_count <= r.obs;
        in_valid          <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
        sent++;
    endtask

    function automatic logic signed [24:0] rand_angle();
        return $urandom_range(0, 23592960) - 11796480;
    endfunction

    function automatic request_t rand_insert();
        request_t r;
        r.op    = OP_INSERT;
        r.q     = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >> $urandom_range(0, 24));
        r.mach  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 24'h60000);
        r.aoa   = rand_angle();
        r.beta  = ($urandom_range(0, 1) == 0) ? rand_angle() : $urandom_range(0, 655360) - 327680;
        r.mass  = $urandom | 32'd1;
        r.drag  = $urandom;
        r.lift  = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 2000000) - 1000000;
        r.side  = $urandom;
        r.frame = $urandom_range(0, 7);
        r.trust = $urandom_range(1, 65535);
        r.obs   = ($urandom_range(0, 7) == 0) ? 16'd0 : $urandom;
        // Now and then a malformed sample that must be rejected.
        case ($urandom_range(0, 19))
            0: r.q = 0;
            1: r.mass = 0;
            2: r.trust = 0;
            default: ;
        endcase
        return r;
    endfunction

    // A query around a stored sample, so that it usually falls inside the radius.
    function automatic request_t near_query();
        request_t r;
        int       idx;
        longint   v;
        r      = rand_insert();
        r.op   = OP_QUERY;
        r.mass = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : ($urandom | 32'd1);
        if (sb.count == 0 || $urandom_range(0, 4) == 0)
            return r;
        idx     = $urandom_range(0, sb.count - 1);
        v       = longint'(sb.b_pres[idx]);
        v       = v + longint'($urandom_range(0, 1000)) * v / 2000 - v / 4;
        if (v < 1)
            v = 1;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        r.q     = v[31:0];
        v       = longint'(sb.b_mach[idx]) + $urandom_range(0, 32768) - 16384;
        r.mach  = (v < 0) ? 24'd0 : v[23:0];
        r.aoa   = sb.b_att[idx] + $urandom_range(0, 655360) - 327680;
        r.beta  = sb.b_slp[idx] + $urandom_range(0, 655360) - 327680;
        r.frame = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : sb.b_frame[idx];
        return r;
    endfunction

    // Result side: random idling, and one long hold-off early on so the
    // block fills its output register and stops taking requests.
    initial
    begin : receiver
        estimate_t act;
        int        got;
        got = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (got == 8)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (draw_gap(got) > 0)
            begin
                out_ready <= 1'b0;
                repeat (draw_gap(got)) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            act.st    = status;
            act.ad    = accel_drag;
            act.al    = accel_lift;
            act.aside = accel_side;
            act.conf  = estimate_confidence;
            sb.check_result(act);
            got++;
        end
    end

    initial
    begin : limit
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : main
        request_t r;
        sb   = new();
        sent = 0;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        opcode            <= OP_INSERT;
        dyn_pressure      <= '0;
        mach_number       <= '0;
        attack_angle      <= '0;
        slip_angle        <= '0;
        vehicle_mass      <= '0;
        drag_per_q        <= '0;
        lift_per_q        <= '0;
        side_per_q        <= '0;
        airframe_bits     <= '0;
        sample_trust      <= '0;
        observation_count <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty bank, rejections, extremes, exact matches.
        r = '{OP_QUERY, 32'h100, 24'h8000, 25'sd0, 25'sd0, 32'h100, 32'sd0, 32'sd0,
              32'sd0, 3'd0, 16'd0, 16'd0};
        send_request(r);
        r.op = OP_INSERT; r.trust = 16'hFFFF; r.obs = 16'd5;
        r.drag = 32'sh0001_0000; r.lift = -32'sh0002_0000; r.side = 32'sh0000_8000;
        send_request(r);
        r.op = OP_QUERY;
        send_request(r);
        r.q = 0;
        send_request(r);
        r.q = 32'h100; r.mass = 0;
        send_request(r);
        r.op = OP_INSERT;
        send_request(r);
        r.mass = 32'h100; r.q = 0;
        send_request(r);
        r.q = 32'h100; r.trust = 0;
        send_request(r);
        r.trust = 16'd1; r.obs = 16'd0; r.mach = 24'h8100;
        send_request(r);
        r = '{OP_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF, 25'sd11796480, -25'sd11796480,
              32'hFFFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000,
              3'd7, 16'hFFFF, 16'hFFFF};
        send_request(r);
        r.op = OP_QUERY; r.mass = 32'd1;
        send_request(r);
        r.aoa = -25'sd11796480; r.beta = 25'sd11796480; r.mass = 32'hFFFF_FFFF;
        send_request(r);
        r = '{OP_INSERT, 32'd1, 24'd0, -25'sd11796480, 25'sd11796480, 32'd1,
              -32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 3'd5, 16'h8000, 16'd1};
        send_request(r);
        r.op = OP_QUERY;
        send_request(r);
        r.mach = 24'd16383;
        send_request(r);
        r.frame = 3'd4;
        send_request(r);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ($urandom_range(0, 9) < 3)
                r = rand_insert();
            else
                r = near_query();
            send_request(r);
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
